// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by lcst_dp
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== design/lcst_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcst_pkg
// Types, codes and constants of the LED column scroll and transpose block.
// ---------------------------------------------------------------------------
package lcst_pkg;

	localparam int STORE_COLUMNS_DEF = 256;
	localparam int MARGIN            = 11;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_SCROLL = 2'd2;
	localparam logic [1:0] OP_RENDER = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ROW    = 1'b1;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  column_index;
		logic [15:0] red_bits;
		logic [15:0] green_bits;
		logic [8:0]  content_width;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  module_res;
		logic [3:0]  row;
		logic [15:0] red_row;
		logic [15:0] green_row;
		logic        wrapped;
		logic        last;
	} res_t;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic wr_read;
		logic wr_write;
		logic scr_init;
		logic mod_step;
		logic copy_step;
		logic pos_update;
		logic res_status;
		logic ld_step;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic mod_done;
		logic copy_done;
		logic ld_last;
		logic row_last;
		logic mod_last;
		logic res_free;
	} sts_t;

endpackage

// ===== design/lcst_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcst_ctrl
// Sequencer: clear sweep, column write, scroll copy and render transpose.
// ---------------------------------------------------------------------------
module lcst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [1:0]        cmd_op,
	output logic              cmd_ready,
	input  lcst_pkg::sts_t    sts,
	output lcst_pkg::ctl_t    ctl
);
	import lcst_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_WRD   = 4'd2;
	localparam logic [3:0] S_WRW   = 4'd3;
	localparam logic [3:0] S_SLEN  = 4'd4;
	localparam logic [3:0] S_SMOD  = 4'd5;
	localparam logic [3:0] S_SCOPY = 4'd6;
	localparam logic [3:0] S_SRES  = 4'd7;
	localparam logic [3:0] S_RLOAD = 4'd8;
	localparam logic [3:0] S_RWAIT = 4'd9;
	localparam logic [3:0] S_REMIT = 4'd10;

	logic [3:0] state_q, state_d;

	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.accept = 1'b1;
					unique case (cmd_op)
						OP_WRITE:  state_d = S_WRD;
						OP_CLEAR:  state_d = S_CLR;
						OP_SCROLL: state_d = S_SLEN;
						OP_RENDER: state_d = S_RLOAD;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_WRD: begin
				ctl.wr_read = 1'b1;
				state_d     = S_WRW;
			end
			S_WRW: begin
				ctl.wr_write = 1'b1;
				state_d      = S_IDLE;
			end
			S_SLEN: begin
				ctl.scr_init = 1'b1;
				state_d      = S_SMOD;
			end
			S_SMOD: begin
				if (sts.mod_done) state_d = S_SCOPY;
				else ctl.mod_step = 1'b1;
			end
			S_SCOPY: begin
				if (sts.copy_done) state_d = S_SRES;
				else ctl.copy_step = 1'b1;
			end
			S_SRES: begin
				if (sts.res_free) begin
					ctl.pos_update = 1'b1;
					ctl.res_status = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_RLOAD: begin
				ctl.ld_step = 1'b1;
				if (sts.ld_last) state_d = S_RWAIT;
			end
			S_RWAIT: begin
				state_d = S_REMIT;
			end
			S_REMIT: begin
				if (sts.res_free) begin
					ctl.emit = 1'b1;
					if (sts.row_last) state_d = sts.mod_last ? S_IDLE : S_RLOAD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

endmodule

// ===== design/lcst_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// lcst_dp
// Column stores, scroll position, transpose buffer and result register.
// ---------------------------------------------------------------------------
module lcst_dp #(
	parameter int STORE_COLUMNS = lcst_pkg::STORE_COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lcst_pkg::cmd_t cmd,
	input  logic           cfg_valid,
	input  logic           cfg_data,
	input  lcst_pkg::ctl_t ctl,
	output lcst_pkg::sts_t sts,
	output logic           res_valid,
	input  logic           res_ready,
	output lcst_pkg::res_t res
);
	import lcst_pkg::*;

	localparam int AW = $clog2(STORE_COLUMNS);
	localparam int LW = (AW + 1 > 10) ? AW + 1 : 10;
	localparam logic [LW-1:0] NCOL = LW'(STORE_COLUMNS);

	cmd_t          item_q;
	logic          rot_q;
	logic [8:0]    pos_q;
	logic [LW-1:0] ctr_q, idx_q, len_q;
	logic          cp_v_s1;
	logic [AW-1:0] cp_a_s1;
	logic [1:0]    mod_q;
	logic [3:0]    k_q, row_q, ld_k_s1;
	logic          ld_v_s1;
	logic [31:0]   buf_q [16];
	logic [31:0]   src_mem [STORE_COLUMNS];
	logic [31:0]   shw_mem [STORE_COLUMNS];
	logic [31:0]   src_rd_q, shw_rd_q;
	res_t          res_q;
	logic          res_valid_q;

	logic [AW-1:0] rd_a, col_a, ld_a;
	logic          col_ok;
	logic          src_we, shw_we;
	logic [AW-1:0] src_wa, shw_wa;
	logic [31:0]   src_wd, shw_wd;
	logic [9:0]    limit, pos_next;
	logic [LW-1:0] len_d;
	logic          wrap;
	logic [1:0]    ms;
	logic [3:0]    ri;
	logic [15:0]   red_w, green_w;

	assign col_a  = AW'(item_q.column_index);
	assign col_ok = LW'(item_q.column_index) < NCOL;
	assign ms     = rot_q ? ~mod_q : mod_q;
	assign ld_a   = AW'({ms, k_q});
	assign limit  = {1'b0, item_q.content_width} + 10'(MARGIN);
	assign len_d  = (LW'(limit) > NCOL) ? NCOL : LW'(limit);
	assign pos_next = {1'b0, pos_q} + 10'd1;
	assign wrap   = pos_next > limit;
	assign ri     = rot_q ? ~row_q : row_q;

	always_comb begin
		rd_a = ld_a;
		if (ctl.wr_read) rd_a = col_a;
		if (ctl.copy_step) rd_a = idx_q[AW-1:0];
		src_we = 1'b0;
		src_wa = ctr_q[AW-1:0];
		src_wd = '0;
		shw_we = 1'b0;
		shw_wa = ctr_q[AW-1:0];
		shw_wd = '0;
		if (ctl.clr_step) begin
			src_we = 1'b1;
			shw_we = 1'b1;
		end
		if (ctl.wr_write && col_ok) begin
			src_we = 1'b1;
			src_wa = col_a;
			src_wd = src_rd_q | {item_q.green_bits, item_q.red_bits};
		end
		if (cp_v_s1) begin
			shw_we = 1'b1;
			shw_wa = cp_a_s1;
			shw_wd = src_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (src_we) src_mem[src_wa] <= src_wd;
		if (shw_we) shw_mem[shw_wa] <= shw_wd;
		src_rd_q <= src_mem[rd_a];
		shw_rd_q <= shw_mem[rd_a];
	end

	always_comb begin
		for (int p = 0; p < 16; p++) begin
			red_w[p]   = buf_q[rot_q ? ~4'(p) : 4'(p)][ri];
			green_w[p] = buf_q[rot_q ? ~4'(p) : 4'(p)][5'd16 + 5'(ri)];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) item_q <= cmd;
		if (ctl.scr_init) len_q <= len_d;
		if (ctl.scr_init) idx_q <= LW'(pos_q);
		else if (ctl.mod_step) idx_q <= idx_q - len_q;
		else if (ctl.copy_step) idx_q <= (idx_q + 1'b1 == len_q) ? '0 : idx_q + 1'b1;
		cp_a_s1 <= ctr_q[AW-1:0];
		ld_k_s1 <= k_q;
		if (ld_v_s1) buf_q[ld_k_s1] <= (pos_q != 9'd0) ? shw_rd_q : src_rd_q;
		if (ctl.res_status) begin
			res_q <= '{kind: KIND_STATUS, module_res: 2'd0, row: 4'd0, red_row: 16'd0,
				green_row: 16'd0, wrapped: wrap, last: 1'b1};
		end else if (ctl.emit) begin
			res_q <= '{kind: KIND_ROW, module_res: mod_q, row: row_q, red_row: red_w,
				green_row: green_w, wrapped: 1'b0,
				last: (mod_q == 2'd3) && (row_q == 4'd15)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q       <= 1'b0;
			pos_q       <= '0;
			ctr_q       <= '0;
			cp_v_s1     <= 1'b0;
			ld_v_s1     <= 1'b0;
			mod_q       <= '0;
			k_q         <= '0;
			row_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) rot_q <= cfg_data;
			if (ctl.pos_update) pos_q <= wrap ? 9'd1 : pos_next[8:0];
			if (ctl.accept || ctl.scr_init) ctr_q <= '0;
			else if (ctl.clr_step || ctl.copy_step) ctr_q <= ctr_q + 1'b1;
			cp_v_s1 <= ctl.copy_step;
			ld_v_s1 <= ctl.ld_step;
			if (ctl.accept) begin
				mod_q <= '0;
				k_q   <= '0;
				row_q <= '0;
			end else begin
				if (ctl.ld_step) k_q <= k_q + 1'b1;
				if (ctl.emit) begin
					row_q <= row_q + 1'b1;
					if (row_q == 4'd15) mod_q <= mod_q + 1'b1;
				end
			end
			if (ctl.res_status || ctl.emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	assign sts.clr_last  = (ctr_q == NCOL - 1'b1);
	assign sts.mod_done  = (idx_q < len_q);
	assign sts.copy_done = (ctr_q + 1'b1 >= len_q);
	assign sts.ld_last   = (k_q == 4'd15);
	assign sts.row_last  = (row_q == 4'd15);
	assign sts.mod_last  = (mod_q == 2'd3);
	assign sts.res_free  = !res_valid_q || res_ready;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`ASSERT_IMPLY(a_copy_idx_in_window, clk, arst_n, ctl.copy_step, idx_q < len_q)
	`ASSERT_IMPLY(a_emit_slot_free, clk, arst_n, ctl.emit || ctl.res_status,
		!res_valid_q || res_ready)
	`ASSERT_NEXT(a_pos_one_after_wrap, clk, arst_n, ctl.pos_update && wrap, pos_q == 9'd1)

endmodule

// ===== design/led_column_scroll_and_transpose.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_column_scroll_and_transpose
// Marquee column stores with scroll window copy and 4x16 row transpose.
// ---------------------------------------------------------------------------
//  channel | signals                  | moves
//  cmd     | cmd_valid/cmd_ready, cmd | one operation per transaction
//  res     | res_valid/res_ready, res | status or one row word
//  cfg     | cfg_valid/cfg_ready      | rotate_head_first
//
//  Write: read-modify-write on the source memory port.
//  Clear: a sweep over every column; reset runs the same clearing pass.
//  Scroll: a modulo subtract loop, then the one-column-per-cycle copy between
//  the two memories; the status result can stall on the output.
//  Render: per module (4), 16 loads into the transpose buffer, a wait state,
//  then 16 row emits, each of which can stall on the output.
// ---------------------------------------------------------------------------
module led_column_scroll_and_transpose #(
	parameter int STORE_COLUMNS = lcst_pkg::STORE_COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  lcst_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output lcst_pkg::res_t res,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);
	import lcst_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lcst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_op    (cmd.op),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	lcst_dp #(
		.STORE_COLUMNS (STORE_COLUMNS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
